@@ design/mpa_pkg.sv @@
// Shared types, constants and saturating arithmetic for the polygon area unit.
`default_nettype none

package mpa_pkg;

    localparam int SUM_W      = 64;
    localparam int OPQ_DEPTH  = 4;
    localparam int RESQ_DEPTH = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // What a vertex does to the open part and polygon
    typedef enum logic [1:0] {
        KIND_FIRST,     // no polygon open: vertex opens one
        KIND_CONT,      // same part: one more shoelace edge
        KIND_PART,      // new part in the same polygon
        KIND_POLY       // new polygon: previous one is emitted
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        logic     hole;
        logic     last;
    } op_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0] value;
        logic             sat;
    } sat_sum_t;

    typedef struct packed {
        logic we0;
        logic we1;
    } res_wr_t;

    // Two's complement add clamped to the signed 64-bit range
    function automatic sat_sum_t sat_add(input logic [SUM_W-1:0] a, input logic [SUM_W-1:0] b);
        sat_sum_t         res;
        logic [SUM_W-1:0] r;
        r         = a + b;
        res.value = r;
        res.sat   = 1'b0;
        if (!a[SUM_W-1] && !b[SUM_W-1] && r[SUM_W-1]) begin
            res.value = SUM_MAX;
            res.sat   = 1'b1;
        end else if (a[SUM_W-1] && b[SUM_W-1] && !r[SUM_W-1]) begin
            res.value = SUM_MIN;
            res.sat   = 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/mpa_opq.sv @@
// Small FIFO carrying classified vertices from the front end to the back end.
`default_nettype none

module mpa_opq #(
    parameter int WIDTH = 84,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output logic      [WIDTH-1:0] head_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop_en;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign pop_en     = pop && head_valid;

    always_comb begin
        wr_ptr_next = push   ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ design/mpa_front.sv @@
// Front end: accepts vertex beats and classifies them against the open part and polygon.
`default_nettype none

module mpa_front #(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_x,
    input  wire logic signed [COORD_BITS-1:0] s_y,
    input  wire logic        [ID_BITS-1:0]    s_pol,
    input  wire logic        [ID_BITS-1:0]    s_part,
    input  wire logic                         s_hole,
    input  wire logic                         s_last,
    input  wire logic                         q_full,
    output logic                              op_push,
    output mpa_pkg::op_ctl_t                  op_ctl,
    output logic signed      [COORD_BITS-1:0] op_x,
    output logic signed      [COORD_BITS-1:0] op_y,
    output logic             [ID_BITS-1:0]    op_pol_old,
    output logic             [ID_BITS-1:0]    op_pol_new
);
    import mpa_pkg::*;

    logic               started_reg, started_next;
    logic [ID_BITS-1:0] open_pol_reg, open_part_reg;
    logic               accept;
    op_kind_t           kind;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    always_comb begin
        if (!started_reg) begin
            kind = KIND_FIRST;
        end else if (s_pol != open_pol_reg) begin
            kind = KIND_POLY;
        end else if (s_part != open_part_reg) begin
            kind = KIND_PART;
        end else begin
            kind = KIND_CONT;
        end
        started_next = accept ? !s_last : started_reg;
    end

    assign op_push     = accept;
    assign op_ctl.kind = kind;
    assign op_ctl.hole = s_hole;
    assign op_ctl.last = s_last;
    assign op_x        = s_x;
    assign op_y        = s_y;
    assign op_pol_old  = open_pol_reg;
    assign op_pol_new  = s_pol;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            open_pol_reg  <= '0;
            open_part_reg <= '0;
        end else begin
            started_reg <= started_next;
            if (accept) begin
                open_pol_reg  <= s_pol;
                open_part_reg <= s_part;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_last_closes : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_last) |=> !started_reg)
        else $error("data set end did not close the open polygon");
`endif

endmodule

`default_nettype wire

@@ design/mpa_back.sv @@
// Back end: shoelace products, part and polygon accumulation with saturation, result writes.
`default_nettype none

module mpa_back #(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              op_valid,
    input  wire mpa_pkg::op_ctl_t                  op_ctl,
    input  wire logic signed [COORD_BITS-1:0]      op_x,
    input  wire logic signed [COORD_BITS-1:0]      op_y,
    input  wire logic        [ID_BITS-1:0]         op_pol_old,
    input  wire logic        [ID_BITS-1:0]         op_pol_new,
    output logic                                   op_pop,
    input  wire logic                              res_room,
    output mpa_pkg::res_wr_t                       res_wr,
    output logic [mpa_pkg::SUM_W+ID_BITS+1:0]      res_d0,
    output logic [mpa_pkg::SUM_W+ID_BITS+1:0]      res_d1
);
    import mpa_pkg::*;

    localparam int PROD_W = 2 * COORD_BITS;
    localparam int EDGE_W = PROD_W + 1;

    typedef struct packed {
        logic cont;
        logic close;
        logic hole;
        logic emit_a;
        logic final_a;
        logic emit_b;
    } stage_ctl_t;

    logic adv;

    // vertex state of the open part
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic                         prev_hole_reg;

    // stage 1: products
    logic signed [COORD_BITS-1:0] ca, cb;
    logic signed [PROD_W-1:0]     p0_next, p1_next, p2_next, p3_next;
    logic signed [PROD_W-1:0]     s1_p0_reg, s1_p1_reg, s1_p2_reg, s1_p3_reg;
    stage_ctl_t                   ctl_next, s1_ctl_reg;
    logic                         s1_valid_reg;
    logic [ID_BITS-1:0]           s1_id_a_reg, s1_id_b_reg;

    // stage 2: edge terms
    logic signed [EDGE_W-1:0]     edge_c_next, edge_k_next;
    logic [SUM_W-1:0]             s2_edge_c_reg, s2_edge_k_reg;
    stage_ctl_t                   s2_ctl_reg;
    logic                         s2_valid_reg;
    logic [ID_BITS-1:0]           s2_id_a_reg, s2_id_b_reg;

    // stage 3: part accumulation
    sat_sum_t                     cont_sum;
    logic [SUM_W-1:0]             part_sum_reg, part_sum_next, total_next;
    logic [SUM_W-1:0]             s3_total_reg, s3_edge_k_reg;
    logic                         s3_sat_reg;
    stage_ctl_t                   s3_ctl_reg;
    logic                         s3_valid_reg;
    logic [ID_BITS-1:0]           s3_id_a_reg, s3_id_b_reg;

    // stage 4: close back to the first vertex
    sat_sum_t                     closed;
    logic [SUM_W-1:0]             s4_csum_reg;
    logic                         s4_sat_reg;
    stage_ctl_t                   s4_ctl_reg;
    logic                         s4_valid_reg;
    logic [ID_BITS-1:0]           s4_id_a_reg, s4_id_b_reg;

    // stage 5: magnitude, signed by hole
    logic                         is_min, flip;
    logic [SUM_W-1:0]             val_next;
    logic [SUM_W-1:0]             s5_val_reg;
    logic                         s5_sat_reg;
    stage_ctl_t                   s5_ctl_reg;
    logic                         s5_valid_reg;
    logic [ID_BITS-1:0]           s5_id_a_reg, s5_id_b_reg;

    // stage 6: polygon total
    sat_sum_t                     poly_add;
    logic [SUM_W-1:0]             poly_sum_reg, poly_sum_next;
    logic                         sticky_reg, sticky_next, sticky_now;

    assign adv    = res_room;
    assign op_pop = adv && op_valid;

    // stage 1
    always_comb begin
        ctl_next.cont    = (op_ctl.kind == KIND_CONT);
        ctl_next.close   = (op_ctl.kind == KIND_PART) || (op_ctl.kind == KIND_POLY)
                        || ((op_ctl.kind == KIND_CONT) && op_ctl.last);
        ctl_next.hole    = (op_ctl.kind == KIND_CONT) ? op_ctl.hole : prev_hole_reg;
        ctl_next.emit_a  = (op_ctl.kind == KIND_POLY) || op_ctl.last;
        ctl_next.final_a = (op_ctl.kind != KIND_POLY) && op_ctl.last;
        ctl_next.emit_b  = (op_ctl.kind == KIND_POLY) && op_ctl.last;
        // closing the current part on its last vertex uses the vertex itself as prev
        ca      = ((op_ctl.kind == KIND_CONT) && op_ctl.last) ? op_x : prev_x_reg;
        cb      = ((op_ctl.kind == KIND_CONT) && op_ctl.last) ? op_y : prev_y_reg;
        p0_next = prev_x_reg * op_y;
        p1_next = op_x * prev_y_reg;
        p2_next = ca * first_y_reg;
        p3_next = first_x_reg * cb;
    end

    // stage 2
    always_comb begin
        edge_c_next = s1_p0_reg - s1_p1_reg;
        edge_k_next = s1_p2_reg - s1_p3_reg;
    end

    // stage 3
    always_comb begin
        cont_sum      = sat_add(part_sum_reg, s2_edge_c_reg);
        total_next    = s2_ctl_reg.cont ? cont_sum.value : part_sum_reg;
        part_sum_next = s2_ctl_reg.cont ? cont_sum.value : '0;
    end

    // stage 4
    assign closed = sat_add(s3_total_reg, s3_edge_k_reg);

    // stage 5
    always_comb begin
        is_min = (s4_csum_reg == SUM_MIN);
        flip   = s4_csum_reg[SUM_W-1] ^ s4_ctl_reg.hole;
        if (!s4_ctl_reg.close) begin
            val_next = '0;
        end else if (is_min) begin
            val_next = s4_ctl_reg.hole ? (SUM_MIN + SUM_W'(1)) : SUM_MAX;
        end else begin
            val_next = flip ? (~s4_csum_reg + SUM_W'(1)) : s4_csum_reg;
        end
    end

    // stage 6
    always_comb begin
        poly_add      = sat_add(poly_sum_reg, s5_val_reg);
        sticky_now    = sticky_reg | s5_sat_reg | poly_add.sat;
        res_wr.we0    = adv && s5_valid_reg && s5_ctl_reg.emit_a;
        res_wr.we1    = adv && s5_valid_reg && s5_ctl_reg.emit_b;
        res_d0        = {sticky_now, s5_ctl_reg.final_a, s5_id_a_reg, poly_add.value};
        res_d1        = {1'b0, 1'b1, s5_id_b_reg, {SUM_W{1'b0}}};
        poly_sum_next = poly_sum_reg;
        sticky_next   = sticky_reg;
        if (adv && s5_valid_reg) begin
            poly_sum_next = s5_ctl_reg.emit_a ? '0 : poly_add.value;
            sticky_next   = s5_ctl_reg.emit_a ? 1'b0 : sticky_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_hole_reg <= 1'b0;
            part_sum_reg  <= '0;
            poly_sum_reg  <= '0;
            sticky_reg    <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
        end else begin
            poly_sum_reg <= poly_sum_next;
            sticky_reg   <= sticky_next;
            if (op_pop) begin
                prev_x_reg    <= op_x;
                prev_y_reg    <= op_y;
                prev_hole_reg <= op_ctl.hole;
                if (op_ctl.kind != KIND_CONT) begin
                    first_x_reg <= op_x;
                    first_y_reg <= op_y;
                end
            end
            if (adv) begin
                s1_valid_reg <= op_valid;
                s2_valid_reg <= s1_valid_reg;
                s3_valid_reg <= s2_valid_reg;
                s4_valid_reg <= s3_valid_reg;
                s5_valid_reg <= s4_valid_reg;
                if (s2_valid_reg) begin
                    part_sum_reg <= part_sum_next;
                end
            end
        end
        if (adv) begin
            s1_p0_reg     <= p0_next;
            s1_p1_reg     <= p1_next;
            s1_p2_reg     <= p2_next;
            s1_p3_reg     <= p3_next;
            s1_ctl_reg    <= ctl_next;
            s1_id_a_reg   <= (op_ctl.kind == KIND_POLY) ? op_pol_old : op_pol_new;
            s1_id_b_reg   <= op_pol_new;

            s2_edge_c_reg <= {{(SUM_W-EDGE_W){edge_c_next[EDGE_W-1]}}, edge_c_next};
            s2_edge_k_reg <= {{(SUM_W-EDGE_W){edge_k_next[EDGE_W-1]}}, edge_k_next};
            s2_ctl_reg    <= s1_ctl_reg;
            s2_id_a_reg   <= s1_id_a_reg;
            s2_id_b_reg   <= s1_id_b_reg;

            s3_total_reg  <= total_next;
            s3_edge_k_reg <= s2_edge_k_reg;
            s3_sat_reg    <= s2_ctl_reg.cont && cont_sum.sat;
            s3_ctl_reg    <= s2_ctl_reg;
            s3_id_a_reg   <= s2_id_a_reg;
            s3_id_b_reg   <= s2_id_b_reg;

            s4_csum_reg   <= closed.value;
            s4_sat_reg    <= s3_sat_reg | (s3_ctl_reg.close && closed.sat);
            s4_ctl_reg    <= s3_ctl_reg;
            s4_id_a_reg   <= s3_id_a_reg;
            s4_id_b_reg   <= s3_id_b_reg;

            s5_val_reg    <= val_next;
            s5_sat_reg    <= s4_sat_reg | (s4_ctl_reg.close && is_min);
            s5_ctl_reg    <= s4_ctl_reg;
            s5_id_a_reg   <= s4_id_a_reg;
            s5_id_b_reg   <= s4_id_b_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        !res_room |=> $stable(poly_sum_reg) && $stable(part_sum_reg))
        else $error("accumulators moved while the result queue was full");
`endif

endmodule

`default_nettype wire

@@ design/mpa_resq.sv @@
// Result queue: takes up to two results a cycle, hands out one beat at a time.
`default_nettype none

module mpa_resq #(
    parameter int WIDTH = 82,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire mpa_pkg::res_wr_t wr,
    input  wire logic [WIDTH-1:0] d0,
    input  wire logic [WIDTH-1:0] d1,
    input  wire logic             pop,
    output logic                  room,
    output logic                  head_valid,
    output logic      [WIDTH-1:0] head_data
);
    import mpa_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop_en;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // room for two writes whatever the reader does this cycle
    assign room       = (count_reg <= CNT_W'(DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign pop_en     = pop && head_valid;

    always_comb begin
        wr_ptr_inc  = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr.we1 ? ptr_inc(wr_ptr_inc) : (wr.we0 ? wr_ptr_inc : wr_ptr_reg);
        rd_ptr_next = pop_en ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr.we0) + CNT_W'(wr.we1) - CNT_W'(pop_en);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (wr.we0) begin
            mem_reg[wr_ptr_reg] <= d0;
        end
        if (wr.we1) begin
            mem_reg[wr_ptr_inc] <= d1;
        end
    end

`ifndef NO_ASSERTIONS
    a_pair_order : assert property (@(posedge aclk) disable iff (!aresetn)
        wr.we1 |-> wr.we0)
        else $error("second result written without the first");
    a_no_overrun : assert property (@(posedge aclk) disable iff (!aresetn)
        wr.we0 |-> (count_reg <= CNT_W'(DEPTH - 2)))
        else $error("result written without room for a pair");
    a_count_step : assert property (@(posedge aclk) disable iff (!aresetn)
        (!wr.we0 && !pop_en) |=> $stable(count_reg))
        else $error("result count moved with no write and no read");
`endif

endmodule

`default_nettype wire

@@ design/multipart_polygon_area_unit.sv @@
// Top level of the multi-part polygon area unit.
`default_nettype none

// Streams polygon vertices in and returns twice the area of each finished
// polygon. Every vertex beat carries x/y, a polygon id and a part id; a part
// lasts while both ids stay the same, is closed back to its first vertex, and
// its absolute shoelace sum is added to the polygon total (subtracted when the
// part's last vertex is flagged as a hole). A change of polygon id emits the
// previous polygon's total; a beat with tlast closes everything and emits a
// result with m_tlast set, so a beat that both changes polygon and ends the
// data yields two results, the second a one-vertex polygon with area 0. All
// sums clamp at the signed 64-bit limits and m_tuser reports any clamp in that
// polygon. One vertex is taken per clock while s_tready is high. A result is
// offered once the beat that causes it has passed the four-beat vertex queue
// and the six-stage back end (multiplier, edge difference, part accumulator,
// closing add, magnitude, polygon accumulator), whose last stage writes the
// result queue. The back end stalls when its four-entry result queue has room
// for fewer than two results; that happens while the result side is held off,
// or when beats that each yield two results come faster than one result a
// clock drains. s_tready drops only once the vertex queue has then filled.
module multipart_polygon_area_unit #(
    parameter int COORD_BITS = 24,
    parameter int ID_BITS    = 16
) (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    // slave side: vertex beats
    input  wire logic                                            s_tvalid,
    output logic                                                 s_tready,
    // x_coord, y_coord, polygon_id, part_id (lowest bits first), zero padded
    input  wire logic [((2*COORD_BITS+2*ID_BITS+7)/8)*8-1:0]     s_tdata,
    // is_hole
    input  wire logic                                            s_tuser,
    // end_of_data
    input  wire logic                                            s_tlast,
    // master side: polygon results
    output logic                                                 m_tvalid,
    input  wire logic                                            m_tready,
    // doubled_area, result_polygon (lowest bits first), zero padded
    output logic [((mpa_pkg::SUM_W+ID_BITS+7)/8)*8-1:0]          m_tdata,
    // saturated
    output logic                                                 m_tuser,
    // final_result
    output logic                                                 m_tlast
);
    import mpa_pkg::*;

    localparam int M_TDATA_W = ((SUM_W + ID_BITS + 7) / 8) * 8;
    localparam int CTL_W     = $bits(op_ctl_t);
    localparam int OP_W      = 2 * COORD_BITS + 2 * ID_BITS + CTL_W;
    localparam int RES_W     = SUM_W + ID_BITS + 2;

    // input fields
    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic        [ID_BITS-1:0]    in_pol, in_part;

    assign in_x    = s_tdata[COORD_BITS-1:0];
    assign in_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_pol  = s_tdata[2*COORD_BITS+ID_BITS-1:2*COORD_BITS];
    assign in_part = s_tdata[2*COORD_BITS+2*ID_BITS-1:2*COORD_BITS+ID_BITS];

    // front end to vertex queue
    logic                         q_full, q_push;
    op_ctl_t                      f_ctl;
    logic signed [COORD_BITS-1:0] f_x, f_y;
    logic        [ID_BITS-1:0]    f_pol_old, f_pol_new;

    // vertex queue to back end
    logic                         q_valid, q_pop;
    logic        [OP_W-1:0]       q_head;
    op_ctl_t                      b_ctl;
    logic signed [COORD_BITS-1:0] b_x, b_y;
    logic        [ID_BITS-1:0]    b_pol_old, b_pol_new;

    // back end to result queue
    res_wr_t                      r_wr;
    logic        [RES_W-1:0]      r_d0, r_d1, r_head;
    logic                         r_room;

    mpa_front #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_x        (in_x),
        .s_y        (in_y),
        .s_pol      (in_pol),
        .s_part     (in_part),
        .s_hole     (s_tuser),
        .s_last     (s_tlast),
        .q_full     (q_full),
        .op_push    (q_push),
        .op_ctl     (f_ctl),
        .op_x       (f_x),
        .op_y       (f_y),
        .op_pol_old (f_pol_old),
        .op_pol_new (f_pol_new)
    );

    mpa_opq #(
        .WIDTH (OP_W),
        .DEPTH (OPQ_DEPTH)
    ) u_opq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  ({f_ctl, f_pol_new, f_pol_old, f_y, f_x}),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    assign b_x       = q_head[COORD_BITS-1:0];
    assign b_y       = q_head[2*COORD_BITS-1:COORD_BITS];
    assign b_pol_old = q_head[2*COORD_BITS+ID_BITS-1:2*COORD_BITS];
    assign b_pol_new = q_head[2*COORD_BITS+2*ID_BITS-1:2*COORD_BITS+ID_BITS];
    assign b_ctl     = op_ctl_t'(q_head[OP_W-1:OP_W-CTL_W]);

    mpa_back #(
        .COORD_BITS (COORD_BITS),
        .ID_BITS    (ID_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op_valid   (q_valid),
        .op_ctl     (b_ctl),
        .op_x       (b_x),
        .op_y       (b_y),
        .op_pol_old (b_pol_old),
        .op_pol_new (b_pol_new),
        .op_pop     (q_pop),
        .res_room   (r_room),
        .res_wr     (r_wr),
        .res_d0     (r_d0),
        .res_d1     (r_d1)
    );

    mpa_resq #(
        .WIDTH (RES_W),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (r_wr),
        .d0         (r_d0),
        .d1         (r_d1),
        .pop        (m_tready),
        .room       (r_room),
        .head_valid (m_tvalid),
        .head_data  (r_head)
    );

    // result entry: {saturated, final_result, result_polygon, doubled_area}
    assign m_tdata = M_TDATA_W'(r_head[SUM_W+ID_BITS-1:0]);
    assign m_tlast = r_head[SUM_W+ID_BITS];
    assign m_tuser = r_head[SUM_W+ID_BITS+1];

endmodule

`default_nettype wire

@@ verif/tb_multipart_polygon_area_unit.sv @@
// Self-checking stream testbench for the multi-part polygon area unit.
module tb_multipart_polygon_area_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 24;
    localparam int ID_BITS    = 16;
    localparam int S_W        = ((2*COORD_BITS+2*ID_BITS+7)/8)*8;
    localparam int M_W        = ((mpa_pkg::SUM_W+ID_BITS+7)/8)*8;

    localparam longint AREA_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint AREA_MIN = 64'sh8000_0000_0000_0000;

    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // cycles without any accepted beat before the run is abandoned
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    // each square edge adds about 2^47: a few laps give large sums below the clamp
    localparam int SQUARE_LOOPS = 4;
    localparam int HOLD_CYCLES  = 120;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [ID_BITS-1:0]           poly;
        logic [ID_BITS-1:0]           part;
        logic                         hole;
        logic                         eod;
    } vertex_t;

    typedef struct packed {
        logic [mpa_pkg::SUM_W-1:0] area;
        logic [ID_BITS-1:0]        poly;
        logic                      is_final;
        logic                      sat;
    } area_result_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;
    logic           s_tuser  = 1'b0;
    logic           s_tlast  = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic           m_tuser;
    logic           m_tlast;

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int          rx_hold_left = 0;
    int          err_count    = 0;

    area_result_t expected_areas[$];

    // predictor state: the part and polygon now open
    logic [ID_BITS-1:0] open_poly  = '0;
    logic [ID_BITS-1:0] open_part  = '0;
    longint             first_x    = 0;
    longint             first_y    = 0;
    longint             prev_x     = 0;
    longint             prev_y     = 0;
    longint             part_acc   = 0;
    longint             poly_acc   = 0;
    bit                 prev_hole  = 1'b0;
    bit                 poly_open  = 1'b0;
    bit                 clamp_seen = 1'b0;

    multipart_polygon_area_unit #(
        .COORD_BITS(COORD_BITS),
        .ID_BITS   (ID_BITS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_add(input longint a, input longint b);
        longint r;
        r = a + b;
        if (a >= 0 && b >= 0 && r < 0) begin
            clamp_seen = 1'b1;
            return AREA_MAX;
        end
        if (a < 0 && b < 0 && r >= 0) begin
            clamp_seen = 1'b1;
            return AREA_MIN;
        end
        return r;
    endfunction

    // close the open ring back to its first vertex and fold |sum| into the polygon, negated for a hole
    function automatic void close_ring();
        longint ring;
        ring = clamp_add(part_acc, prev_x * first_y - first_x * prev_y);
        if (ring == AREA_MIN) begin
            clamp_seen = 1'b1;
            ring = AREA_MAX;
        end else if (ring < 0) begin
            ring = -ring;
        end
        poly_acc = clamp_add(poly_acc, prev_hole ? -ring : ring);
        part_acc = 0;
    endfunction

    function automatic void open_ring(input vertex_t v);
        open_poly = v.poly;
        open_part = v.part;
        first_x   = v.x;
        first_y   = v.y;
        prev_x    = v.x;
        prev_y    = v.y;
        part_acc  = 0;
    endfunction

    function automatic void emit_area(input bit is_final);
        area_result_t r;
        r.area     = poly_acc;
        r.poly     = open_poly;
        r.is_final = is_final;
        r.sat      = clamp_seen;
        expected_areas.insert(expected_areas.size(), r);
        poly_acc   = 0;
        clamp_seen = 1'b0;
    endfunction

    function automatic void predict_polygon_areas(input vertex_t v);
        longint xv, yv;
        xv = v.x;
        yv = v.y;
        if (!poly_open) begin
            poly_acc   = 0;
            clamp_seen = 1'b0;
            open_ring(v);
            poly_open  = 1'b1;
        end else if (v.poly != open_poly || v.part != open_part) begin
            close_ring();
            if (v.poly != open_poly)
                emit_area(1'b0);
            open_ring(v);
        end else begin
            part_acc = clamp_add(part_acc, prev_x * yv - xv * prev_y);
            prev_x   = xv;
            prev_y   = yv;
        end
        prev_hole = v.hole;
        if (v.eod) begin
            close_ring();
            emit_area(1'b1);
            poly_open = 1'b0;
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic vertex_t make_vertex(input logic [COORD_BITS-1:0] x,
                                            input logic [COORD_BITS-1:0] y,
                                            input logic [ID_BITS-1:0] poly,
                                            input logic [ID_BITS-1:0] part,
                                            input logic hole, input logic eod);
        vertex_t v;
        v.x    = x;
        v.y    = y;
        v.poly = poly;
        v.part = part;
        v.hole = hole;
        v.eod  = eod;
        return v;
    endfunction

    // half full-range, half close to the origin
    function automatic logic [COORD_BITS-1:0] rand_coord();
        if ($urandom_range(1))
            return COORD_BITS'($urandom);
        return COORD_BITS'($urandom_range(200) - 100);
    endfunction

    // offer one vertex beat; tvalid is only lowered when a gap is taken
    task automatic send_vertex(input vertex_t v);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({v.part, v.poly, v.y, v.x});
        s_tuser  <= v.hole;
        s_tlast  <= v.eod;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_polygon_areas(v);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_cases();
        // first vertex opens polygon 0 / part 0, then a quad to the positive corner
        send_vertex(make_vertex(0,     0,     16'h0000, 16'h0000, 1'b0, 1'b0));
        send_vertex(make_vertex(C_MAX, 0,     16'h0000, 16'h0000, 1'b0, 1'b0));
        send_vertex(make_vertex(C_MAX, C_MAX, 16'h0000, 16'h0000, 1'b0, 1'b0));
        send_vertex(make_vertex(0,     C_MAX, 16'h0000, 16'h0000, 1'b0, 1'b0));
        // new part in the same polygon, hole flagged on its last vertex only
        send_vertex(make_vertex(C_MIN, C_MIN, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
        send_vertex(make_vertex(0,     C_MIN, 16'h0000, 16'hFFFF, 1'b0, 1'b0));
        send_vertex(make_vertex(0,     0,     16'h0000, 16'hFFFF, 1'b1, 1'b0));
        // single-vertex part: closes to zero
        send_vertex(make_vertex(5,     7,     16'h0000, 16'h0003, 1'b0, 1'b0));
        // polygon change emits polygon 0; hole flag dropped on the last vertex
        send_vertex(make_vertex(C_MIN, C_MAX, 16'hFFFF, 16'h0000, 1'b1, 1'b0));
        send_vertex(make_vertex(C_MAX, C_MIN, 16'hFFFF, 16'h0000, 1'b1, 1'b0));
        send_vertex(make_vertex(C_MIN, C_MIN, 16'hFFFF, 16'h0000, 1'b0, 1'b0));
        // polygon change and end of data on one beat: two results
        send_vertex(make_vertex(1,     1,     16'h1234, 16'h0000, 1'b0, 1'b1));
        // lone vertex with end of data straight after: area 0
        send_vertex(make_vertex(C_MAX, C_MAX, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        // outer of 100 minus a clockwise hole of 10000: negative total
        send_vertex(make_vertex(0,     0,     16'h0007, 16'h0001, 1'b0, 1'b0));
        send_vertex(make_vertex(10,    0,     16'h0007, 16'h0001, 1'b0, 1'b0));
        send_vertex(make_vertex(0,     10,    16'h0007, 16'h0001, 1'b0, 1'b0));
        send_vertex(make_vertex(0,     0,     16'h0007, 16'h0002, 1'b0, 1'b0));
        send_vertex(make_vertex(0,     100,   16'h0007, 16'h0002, 1'b0, 1'b0));
        send_vertex(make_vertex(100,   0,     16'h0007, 16'h0002, 1'b1, 1'b0));
        // end of data on a multi-vertex polygon
        send_vertex(make_vertex(C_MIN, C_MAX, 16'h0008, 16'h0000, 1'b0, 1'b0));
        send_vertex(make_vertex(C_MIN, C_MIN, 16'h0008, 16'h0000, 1'b0, 1'b0));
        send_vertex(make_vertex(C_MAX, C_MIN, 16'h0008, 16'h0000, 1'b0, 1'b1));
    endtask

    // mostly well-formed polygons with random content, the rest stray vertices
    task automatic test_random_polygons(input int n_vertices);
        int                 sent;
        int                 n_parts;
        int                 n_verts;
        logic [ID_BITS-1:0] poly;
        logic [ID_BITS-1:0] part;
        bit                 ring_hole;
        bit                 ends_data;
        sent = 0;
        poly = '0;
        part = '0;
        while (sent < n_vertices) begin
            if ($urandom_range(99) < 85) begin
                poly      = ID_BITS'($urandom);
                n_parts   = $urandom_range(1, 3);
                ends_data = ($urandom_range(9) == 0);
                for (int p = 0; p < n_parts; p++) begin
                    part      = ID_BITS'($urandom);
                    n_verts   = $urandom_range(1, 6);
                    ring_hole = (p > 0) && $urandom_range(1);
                    for (int k = 0; k < n_verts; k++) begin
                        send_vertex(make_vertex(rand_coord(), rand_coord(), poly, part,
                                                ring_hole ^ ($urandom_range(15) == 0),
                                                ends_data && p == n_parts-1 && k == n_verts-1));
                        sent++;
                    end
                end
            end else begin
                send_vertex(make_vertex(rand_coord(), rand_coord(), ID_BITS'($urandom),
                                        ID_BITS'($urandom), 1'($urandom_range(1)),
                                        $urandom_range(7) == 0));
                sent++;
            end
        end
        // flush whatever is still open
        if (poly_open)
            send_vertex(make_vertex(rand_coord(), rand_coord(), open_poly, open_part,
                                    1'b0, 1'b1));
    endtask

    // result side held off while two-vertex polygons keep coming: input must stall
    task automatic test_output_backpressure();
        rx_hold_left = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_vertex(make_vertex(rand_coord(), rand_coord(), ID_BITS'(1000 + i/2),
                                    ID_BITS'(i % 3), 1'($urandom_range(1)), i == 39));
    endtask

    // full-range square traversed a few times, both directions: large part sums
    task automatic test_large_squares();
        logic signed [COORD_BITS-1:0] sq_x[4];
        logic signed [COORD_BITS-1:0] sq_y[4];
        sq_x = '{C_MAX, C_MIN, C_MIN, C_MAX};
        sq_y = '{C_MAX, C_MAX, C_MIN, C_MIN};
        // anticlockwise laps, then a large triangle as a second part
        for (int k = 0; k < SQUARE_LOOPS; k++)
            for (int c = 0; c < 4; c++)
                send_vertex(make_vertex(sq_x[c], sq_y[c], 16'h5A5A, 16'h0001, 1'b0, 1'b0));
        send_vertex(make_vertex(C_MIN, C_MIN, 16'h5A5A, 16'h0002, 1'b0, 1'b0));
        send_vertex(make_vertex(C_MAX, C_MIN, 16'h5A5A, 16'h0002, 1'b0, 1'b0));
        send_vertex(make_vertex(C_MAX, C_MAX, 16'h5A5A, 16'h0002, 1'b0, 1'b0));
        // clockwise hole laps: negative part sum, negative total
        for (int k = 0; k < SQUARE_LOOPS; k++)
            for (int c = 3; c >= 0; c--)
                send_vertex(make_vertex(sq_x[c], sq_y[c], 16'hA5A5, 16'h0001, 1'b1, 1'b0));
        send_vertex(make_vertex(C_MAX, C_MAX, 16'hA5A5, 16'h0002, 1'b1, 1'b0));
        send_vertex(make_vertex(C_MAX, C_MIN, 16'hA5A5, 16'h0002, 1'b1, 1'b0));
        send_vertex(make_vertex(C_MIN, C_MIN, 16'hA5A5, 16'h0002, 1'b1, 1'b1));
    endtask

    // ---------------------------------------------------------------- result side

    // m_tready pattern; a pending hold-off overrides the random idling
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        area_result_t got;
        area_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.area     = m_tdata[mpa_pkg::SUM_W-1:0];
            got.poly     = m_tdata[mpa_pkg::SUM_W +: ID_BITS];
            got.is_final = m_tlast;
            got.sat      = m_tuser;
            if (expected_areas.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result beat area=%0d poly=%h final=%b sat=%b",
                         $time, $signed(got.area), got.poly, got.is_final, got.sat);
            end else begin
                want = expected_areas.pop_front();
                if (got !== want) begin
                    err_count++;
                    $display("%0t: mismatch expected %0d/%h/%b/%b actual %0d/%h/%b/%b",
                             $time, $signed(want.area), want.poly, want.is_final, want.sat,
                             $signed(got.area), got.poly, got.is_final, got.sat);
                end
            end
        end
    end

    // watchdog: too long without any beat on either side
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // sender mostly busy, receiver mostly stalling
        tx_idle_pct = 29;
        rx_idle_pct = 69;
        test_directed_cases();
        test_random_polygons(140);

        // roles swapped
        tx_idle_pct = 69;
        rx_idle_pct = 29;
        test_random_polygons(140);

        // full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_polygons(140);
        test_output_backpressure();
        test_large_squares();

        s_tvalid <= 1'b0;
        while (expected_areas.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
